FILE: rtl/srtf_preemptive_scheduler_defines.svh
// ----------------------------------------------------------------------------
// srtf scheduler assertion macros
// shared concurrent check wrappers, clocked on clk and gated by reset
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_DEFINES_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_DEFINES_SVH

// same-cycle implication check
`define SRTF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srtf scheduler check failed");

// next-cycle implication check
`define SRTF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srtf scheduler check failed");

`endif

FILE: rtl/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf scheduler package
// shared types, request codes and result codes
// ----------------------------------------------------------------------------
package srtf_pkg;

    // request function codes
    localparam logic FUNC_ARRIVE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // result status codes
    localparam logic [2:0] ST_ACCEPTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_RAN      = 3'd2;
    localparam logic [2:0] ST_IDLE     = 3'd3;
    localparam logic [2:0] ST_DONE     = 3'd4;

    // one job table entry
    typedef struct packed {
        logic [7:0]  job;
        logic [15:0] burst;
        logic [31:0] arrival;
        logic [15:0] remaining;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH,
        S_REPORT
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
        logic report;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_last;
    } sts_t;

endpackage

FILE: rtl/srtf_ram.sv
// ----------------------------------------------------------------------------
// srtf generic ram
// single write port, single read port with registered read data
// ----------------------------------------------------------------------------
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/srtf_ctrl.sv
// ----------------------------------------------------------------------------
// srtf controller
// sequences the table scan, the update and the result strobe
// ----------------------------------------------------------------------------
module srtf_ctrl
    import srtf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output logic busy,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:  state_next = S_FINISH;
            S_FINISH: state_next = S_REPORT;
            S_REPORT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy       = (state_reg != S_IDLE);
        cmd.load   = (state_reg == S_IDLE) && start;
        cmd.scan   = (state_reg == S_SCAN);
        cmd.finish = (state_reg == S_FINISH);
        cmd.report = (state_reg == S_REPORT);
    end

endmodule

FILE: rtl/srtf_dp.sv
// ----------------------------------------------------------------------------
// srtf datapath
// job table, occupancy bits, clock counter, best-job search and result regs
// ----------------------------------------------------------------------------
module srtf_dp
    import srtf_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        func,
    input  logic [7:0]  job_id,
    input  logic [15:0] burst_time,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  served_id,
    output logic [31:0] wait_time,
    output logic [31:0] turnaround_time
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    // request latches
    logic        func_reg;
    logic [7:0]  job_reg;
    logic [15:0] burst_reg;

    // control state
    logic [IDX_W-1:0] cnt_reg;
    logic             cmp_vld_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic [SLOTS-1:0] used_reg;
    logic [SLOTS-1:0] used_next;
    logic [31:0]      time_reg;
    logic [31:0]      time_next;
    logic             best_found_reg;
    logic             free_found_reg;
    logic             done_reg;

    // search results
    logic [IDX_W-1:0] best_idx_reg;
    logic [IDX_W-1:0] free_idx_reg;
    entry_t           best_reg;
    logic [31:0]      turn_reg;
    logic [31:0]      turn_next;

    // result registers
    logic [2:0]  status_reg;
    logic [7:0]  served_id_reg;
    logic [31:0] wait_time_reg;
    logic [31:0] turnaround_time_reg;

    // table port signals
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;
    entry_t             wr_entry;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;

    logic cand_used;
    logic cand_beats;
    logic best_last;
    logic arrive_ok;
    logic tick_keep;

    assign rd_entry = entry_t'(ram_rdata);
    assign sts.scan_last = (cnt_reg == LAST_IDX);

    // job table
    srtf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .re    (cmd.scan),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    // candidate compare: remaining, then arrival, then id; slot order keeps ties
    assign cand_used  = used_reg[cmp_idx_reg];
    assign cand_beats = !best_found_reg ||
                        ({rd_entry.remaining, rd_entry.arrival, rd_entry.job} <
                         {best_reg.remaining, best_reg.arrival, best_reg.job});

    // update decode
    assign best_last = (best_reg.remaining <= 16'd1);
    assign arrive_ok = (func_reg == FUNC_ARRIVE) && free_found_reg;
    assign tick_keep = (func_reg == FUNC_TICK) && best_found_reg && !best_last;

    // table write: new job on arrive, decremented remaining on tick
    always_comb
    begin
        ram_we = cmd.finish && (arrive_ok || tick_keep);
        if (func_reg == FUNC_ARRIVE)
        begin
            ram_waddr          = free_idx_reg;
            wr_entry.job       = job_reg;
            wr_entry.burst     = burst_reg;
            wr_entry.arrival   = time_reg;
            wr_entry.remaining = burst_reg;
        end
        else
        begin
            ram_waddr          = best_idx_reg;
            wr_entry.job       = best_reg.job;
            wr_entry.burst     = best_reg.burst;
            wr_entry.arrival   = best_reg.arrival;
            wr_entry.remaining = best_reg.remaining - 16'd1;
        end
    end

    // occupancy, time and turnaround next values
    always_comb
    begin
        used_next = used_reg;
        time_next = time_reg;
        turn_next = turn_reg;
        if (cmd.finish)
        begin
            if (arrive_ok)
            begin
                used_next[free_idx_reg] = 1'b1;
            end
            if (func_reg == FUNC_TICK)
            begin
                time_next = time_reg + 32'd1;
                turn_next = time_next - best_reg.arrival;
                if (best_found_reg && best_last)
                begin
                    used_next[best_idx_reg] = 1'b0;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            cmp_vld_reg    <= 1'b0;
            used_reg       <= '0;
            time_reg       <= '0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            cmp_vld_reg <= cmd.scan;
            used_reg    <= used_next;
            time_reg    <= time_next;
            done_reg    <= cmd.report;
            if (cmd.load)
            begin
                cnt_reg        <= '0;
                best_found_reg <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    cnt_reg <= cnt_reg + IDX_W'(1);
                end
                if (cmp_vld_reg)
                begin
                    if (cand_used && cand_beats)
                    begin
                        best_found_reg <= 1'b1;
                    end
                    if (!cand_used)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmp_idx_reg <= cnt_reg;
        turn_reg    <= turn_next;
        if (cmd.load)
        begin
            func_reg  <= func;
            job_reg   <= job_id;
            burst_reg <= burst_time;
        end
        if (cmp_vld_reg)
        begin
            if (cand_used && cand_beats)
            begin
                best_reg     <= rd_entry;
                best_idx_reg <= cmp_idx_reg;
            end
            if (!cand_used && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // result formatting
    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            wait_time_reg       <= '0;
            turnaround_time_reg <= '0;
            if (func_reg == FUNC_ARRIVE)
            begin
                status_reg    <= free_found_reg ? ST_ACCEPTED : ST_FULL;
                served_id_reg <= job_reg;
            end
            else if (!best_found_reg)
            begin
                status_reg    <= ST_IDLE;
                served_id_reg <= '0;
            end
            else if (best_last)
            begin
                status_reg          <= ST_DONE;
                served_id_reg       <= best_reg.job;
                turnaround_time_reg <= turn_reg;
                wait_time_reg       <= turn_reg - {16'd0, best_reg.burst};
            end
            else
            begin
                status_reg    <= ST_RAN;
                served_id_reg <= best_reg.job;
            end
        end
    end

    assign done            = done_reg;
    assign status          = status_reg;
    assign served_id       = served_id_reg;
    assign wait_time       = wait_time_reg;
    assign turnaround_time = turnaround_time_reg;

endmodule

FILE: rtl/srtf_preemptive_scheduler.sv
// ----------------------------------------------------------------------------
// srtf preemptive scheduler
// Shortest-remaining-time-first job scheduler over SLOTS table entries. A
// request is taken when start is high and busy is low; func selects an
// arrival (job_id, burst_time) or a one-unit time tick. Every request gives
// exactly one result, shown for a single cycle with done high; the receiver
// cannot stall it, so it must capture the result in that cycle. The job table
// is read one entry per cycle through its single read port, then come a
// drain, an update and a report state. busy falls as done rises, so a new
// request may be issued in the same cycle that the result appears.
// wait_time and turnaround_time are nonzero only with status job completed.
// ----------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_defines.svh"

module srtf_preemptive_scheduler
    import srtf_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [7:0]  job_id,
    input  logic [15:0] burst_time,
    output logic        done,
    output logic [2:0]  status,
    output logic [7:0]  served_id,
    output logic [31:0] wait_time,
    output logic [31:0] turnaround_time
);

    cmd_t cmd;
    sts_t sts;

    // controller
    srtf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .busy  (busy),
        .cmd   (cmd)
    );

    // datapath
    srtf_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .func            (func),
        .job_id          (job_id),
        .burst_time      (burst_time),
        .done            (done),
        .status          (status),
        .served_id       (served_id),
        .wait_time       (wait_time),
        .turnaround_time (turnaround_time)
    );

    // an accepted request keeps the block busy until its result
    `SRTF_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    // a result only appears once the controller is back at rest
    `SRTF_ASSERT_NOW(a_done_idle, done, !busy && !cmd.scan && !cmd.finish)
    // times are reported only for a completed job
    `SRTF_ASSERT_NOW(a_times_zero, done && (status != ST_DONE),
                     (wait_time == 32'd0) && (turnaround_time == 32'd0))

endmodule
